// ----- design/mtp_pkg.sv -----
// Shared constants and word functions for the Mersenne Twister generator.
`timescale 1ns / 1ps

package mtp_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned OUT_W        = 31;
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned CNT_W        = $clog2(STATE_WORDS);

  localparam logic [CNT_W-1:0]  SEED_LAST    = CNT_W'(STATE_WORDS - 1);
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [16:0]       SEED_MULT    = 17'd69069;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd4357;

  typedef logic [WORD_W-1:0] word_t;

  // One twist step: combine the top bit of the current word with the low bits of the next.
  function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  // Tempering transform applied to each word on its way out.
  function automatic word_t temper_word(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- design/mtp_if.sv -----
// Request and result channel interfaces of the generator.
`timescale 1ns / 1ps

interface mtp_req_if;
  logic valid;
  logic ready;
  logic reseed;

  modport source (output valid, output reseed, input ready);
  modport sink (input valid, input reseed, output ready);
endinterface

interface mtp_rsp_if import mtp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

// ----- design/mersenne_twister_prng_unit.sv -----
// Top level: 32-bit Mersenne Twister built as a ring of 624 word cells.
// A plain request's result is registered and appears in the cycle after acceptance; one request
// per cycle is sustained while the result side stays ready. A reseed request, or the first
// request after reset, first runs a seeding pass through the 32x17 seed multiplier at the ring
// tail, then a draw, which waits while the previous result is still held.
// Reset leaves the table unseeded and the seed register at 4357; the cell words are not reset.
`timescale 1ns / 1ps

module mersenne_twister_prng_unit import mtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  mtp_req_if.sink     req_i,
  mtp_rsp_if.source   rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEED = 3'b010,
    ST_DRAW = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              seeded_q, seeded_d;
  word_t             seed_q;
  logic              rsp_valid_q, rsp_valid_d;
  logic [OUT_W-1:0]  rsp_data_q, rsp_data_d;

  word_t             ring [STATE_WORDS];
  word_t             push_word;
  word_t             twisted;
  word_t             tempered;
  logic [48:0]       seed_prod;
  logic              shift_en;
  logic              out_free;
  logic              req_fire;
  logic              need_seed;
  logic              draw_fire;

  // Ring of word cells: cell 0 is the head, new words enter at the tail.
  for (genvar g = 0; g < STATE_WORDS; g++) begin : g_cell
    if (g == STATE_WORDS - 1) begin : g_tail
      mtp_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (push_word),
        .word_o  (ring[g])
      );
    end else begin : g_body
      mtp_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (ring[g+1]),
        .word_o  (ring[g])
      );
    end
  end

  // Twisted word from the head, its neighbour and the far tap.
  assign twisted   = twist_word(ring[0], ring[1], ring[TWIST_OFFSET]);
  assign tempered  = temper_word(twisted);
  assign seed_prod = SEED_MULT * ring[STATE_WORDS-1];

  // Handshake decisions.
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign req_fire  = req_i.valid && req_i.ready;
  assign need_seed = req_i.reseed || !seeded_q;
  assign draw_fire = (req_fire && !need_seed) || ((state_q == ST_DRAW) && out_free);
  assign shift_en  = draw_fire || (state_q == ST_SEED);

  // Word pushed into the tail: seed, seed products, or the freshly twisted word.
  always_comb begin
    if (state_q == ST_SEED) begin
      push_word = (cnt_q == '0) ? seed_q : seed_prod[WORD_W-1:0];
    end else begin
      push_word = twisted;
    end
  end

  // Sequencer for seeding and delayed draws.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    seeded_d = seeded_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire && need_seed) begin
          state_d = ST_SEED;
          cnt_d   = '0;
        end
      end
      ST_SEED: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SEED_LAST) begin
          state_d  = ST_DRAW;
          seeded_d = 1'b1;
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_data_d  = rsp_data_q;
    if (draw_fire) begin
      rsp_valid_d = 1'b1;
      rsp_data_d  = tempered[OUT_W-1:0];
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      seed_q      <= SEED_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seeded_q    <= seeded_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_data_q <= rsp_data_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.random_value = rsp_data_q;

`ifndef ASSERT_OFF
  // No request is taken while the ring is being seeded.
  a_no_req_in_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) |-> !req_i.ready)
    else $error("request accepted during seeding");

  // A request that needs seeding starts the seeding pass.
  a_seed_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && need_seed) |=> (state_q == ST_SEED) && (cnt_q == '0))
    else $error("seeding did not start");

  // Seeding ends after the last word and leaves the table seeded.
  a_seed_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SEED) && (cnt_q == SEED_LAST)) |=> (state_q == ST_DRAW) && seeded_q)
    else $error("seeding did not finish correctly");

  // Once seeded the table stays seeded.
  a_seeded_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seeded_q |=> seeded_q)
    else $error("seeded flag dropped");
`endif

endmodule

// ----- design/mtp_cell.sv -----
// One word cell of the state shift ring.
`timescale 1ns / 1ps

module mtp_cell import mtp_pkg::*; (
  input  logic  clk_i,
  input  logic  shift_i,
  input  word_t word_i,
  output word_t word_o
);

  word_t word_q;
  word_t word_d;

  // Take the neighbour's word whenever the ring advances.
  assign word_d = shift_i ? word_i : word_q;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the Mersenne Twister generator: table of directed requests, then random.
`timescale 1ns / 1ps

module testbench;
  import mtp_pkg::*;

  typedef logic [OUT_W-1:0] draw_t;

  // Kinds of row in the directed table.
  typedef enum logic [1:0] {
    ROW_DRAW,
    ROW_RESEED,
    ROW_SEED_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    word_t     seed;
    logic      fixed;
    draw_t     fixed_draw;
  } stim_row_t;

  localparam int          DIRECTED_COUNT = 23;
  localparam int unsigned NEVER_SEEDED   = STATE_WORDS + 1;
  // Slowest run: about 1000 requests, each a reseed with the longest gap and the longest stall;
  // the limit allows several times the length of that run.
  localparam int unsigned LIMIT_CYCLES   = 3_000_000;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  cfg_we_i;
  logic  [31:0] cfg_wdata_i;

  mtp_req_if req ();
  mtp_rsp_if rsp ();

  mersenne_twister_prng_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  // Predictor state: its own copy of the table, the read position and the seed register.
  word_t       mt_words [STATE_WORDS];
  int unsigned word_pos = NEVER_SEEDED;
  word_t       seed_reg = SEED_RESET;

  draw_t       pending_draws [$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          sender_calm = 1'b0;
  bit          sink_calm   = 1'b0;
  int unsigned stall_left  = 0;
  logic        row_fixed   = 1'b0;
  draw_t       row_fixed_draw = '0;

  // Directed requests; a fixed draw is only given where the answer is obvious (seed zero).
  stim_row_t directed_rows [0:DIRECTED_COUNT-1] = '{
    '{ROW_DRAW,       32'd0,          1'b0, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b0, 31'd0},
    '{ROW_RESEED,     32'd0,          1'b0, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b0, 31'd0},
    '{ROW_SEED_WRITE, 32'h0000_0000,  1'b0, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b0, 31'd0},
    '{ROW_RESEED,     32'd0,          1'b1, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b1, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b1, 31'd0},
    '{ROW_SEED_WRITE, 32'hffff_ffff,  1'b0, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b1, 31'd0},
    '{ROW_RESEED,     32'd0,          1'b0, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b0, 31'd0},
    '{ROW_RESEED,     32'd0,          1'b0, 31'd0},
    '{ROW_SEED_WRITE, 32'h0000_0001,  1'b0, 31'd0},
    '{ROW_RESEED,     32'd0,          1'b0, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b0, 31'd0},
    '{ROW_SEED_WRITE, 32'h8000_0000,  1'b0, 31'd0},
    '{ROW_RESEED,     32'd0,          1'b0, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b0, 31'd0},
    '{ROW_SEED_WRITE, SEED_RESET,     1'b0, 31'd0},
    '{ROW_RESEED,     32'd0,          1'b0, 31'd0},
    '{ROW_DRAW,       32'd0,          1'b0, 31'd0}
  };

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fill the table from the seed register by repeated multiplication.
  function automatic void seed_words();
    mt_words[0] = seed_reg;
    for (int i = 1; i < STATE_WORDS; i++) begin
      mt_words[i] = mt_words[i-1] * 32'(SEED_MULT);
    end
    word_pos = STATE_WORDS;
  endfunction

  // Regenerate the whole table in place.
  function automatic void twist_words();
    word_t mix;
    word_t fresh;
    for (int k = 0; k < STATE_WORDS; k++) begin
      mix   = (mt_words[k] & HIGH_BIT) | (mt_words[(k + 1) % STATE_WORDS] & LOW_BITS);
      fresh = mt_words[(k + TWIST_OFFSET) % STATE_WORDS] ^ (mix >> 1);
      if (mix[0]) begin
        fresh = fresh ^ TWIST_MATRIX;
      end
      mt_words[k] = fresh;
    end
    word_pos = 0;
  endfunction

  // Next tempered word with the top bit dropped, after any seeding and twisting it needs.
  function automatic draw_t draw_word(input logic reseed_bit);
    word_t w;
    if (reseed_bit) begin
      seed_words();
    end
    if (word_pos >= STATE_WORDS) begin
      if (word_pos != STATE_WORDS) begin
        seed_words();
      end
      twist_words();
    end
    w = mt_words[word_pos];
    word_pos++;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    return w[OUT_W-1:0];
  endfunction

  function automatic void note_fault(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Mostly short gaps, a few long ones, none at all while calm.
  function automatic int unsigned idle_length(input bit calm);
    int unsigned roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Handshakes are sampled mid-cycle, where every signal is settled until the next edge.
  always @(negedge clk_i) begin
    draw_t want;
    if (rst_ni && req.valid && req.ready) begin
      want = draw_word(req.reseed);
      if (row_fixed) begin
        want = row_fixed_draw;
      end
      pending_draws.push_back(want);
    end
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_draws.size() == 0) begin
        note_fault($sformatf("unexpected result: random_value %h", rsp.random_value));
      end else begin
        want = pending_draws.pop_front();
        if (rsp.random_value !== want) begin
          note_fault($sformatf("random_value mismatch: expected %h, got %h",
                               want, rsp.random_value));
        end
      end
    end
  end

  // Result side: random stalls with calm stretches now and then.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) begin
        sink_calm = !sink_calm;
      end
      if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = idle_length(sink_calm);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Issue one request after a random gap and hold it until it is taken.
  task automatic send_request(input logic reseed_bit, input logic fixed, input draw_t fixed_draw);
    int unsigned gap;
    bit          taken;
    if ($urandom_range(0, 49) == 0) begin
      sender_calm = !sender_calm;
    end
    gap = idle_length(sender_calm);
    if (gap > 0) begin
      req.valid  <= 1'b0;
      req.reseed <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    row_fixed      = fixed;
    row_fixed_draw = fixed_draw;
    req.valid  <= 1'b1;
    req.reseed <= reseed_bit;
    do begin
      @(negedge clk_i);
      taken = req.valid && req.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain_results();
    req.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_draws.size() != 0);
  endtask

  // Seed register write, only ever with the generator idle.
  task automatic load_seed(input word_t value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    seed_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Main sequence: reset, directed table, then random phases each under a fresh seed.
  initial begin
    int unsigned item_count;
    logic        reseed_bit;
    req.valid   = 1'b0;
    req.reseed  = 1'b0;
    rsp.ready   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SEED_WRITE) begin
        load_seed(directed_rows[r].seed);
      end else begin
        send_request(directed_rows[r].kind == ROW_RESEED, directed_rows[r].fixed,
                     directed_rows[r].fixed_draw);
      end
    end

    // The first phase runs well past one full table so that the refill twist is exercised.
    for (int phase = 0; phase < 4; phase++) begin
      load_seed($urandom());
      item_count = (phase == 0) ? 650 : 100;
      for (int i = 0; i < item_count; i++) begin
        reseed_bit = (i == 0) || (phase != 0 && $urandom_range(0, 15) == 0);
        if (phase != 0 && $urandom_range(0, 59) == 0) begin
          drain_results();
        end
        send_request(reseed_bit, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (pending_draws.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", pending_draws.size()));
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mtp_pkg.sv
design/mtp_if.sv
design/mtp_cell.sv
design/mersenne_twister_prng_unit.sv
bench/testbench.sv
